// ----- rtl/assert_macros.svh -----
// Assertion helpers: clocked on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define NG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ngahr_pkg.sv -----
package ngahr_pkg;

	localparam int SAMPLE_BITS_DEF     = 24;
	localparam int COEFF_FRAC_BITS_DEF = 16;
	localparam int HOLD_BITS_DEF       = 17;

	localparam int CFG_ADDR_BITS = 5;
	localparam int CFG_DATA_BITS = 32;

	localparam int THRESHOLD_RST    = 83886;
	localparam int GATE_ATTACK_RST  = 1356;
	localparam int GATE_RELEASE_RST = 27;
	localparam int HOLD_RST         = 2400;
	localparam int ENV_ATTACK_RST   = 12573;
	localparam int ENV_RELEASE_RST  = 272;
	localparam int STEREO_RST       = 1;

	typedef enum logic [2:0] {
		REG_THRESHOLD    = 3'd0,
		REG_GATE_ATTACK  = 3'd1,
		REG_GATE_RELEASE = 3'd2,
		REG_HOLD         = 3'd3,
		REG_ENV_ATTACK   = 3'd4,
		REG_ENV_RELEASE  = 3'd5,
		REG_STEREO       = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_ENV,
		OP_GATE,
		OP_GAIN,
		OP_LOUT,
		OP_ROUT
	} op_t;

	typedef enum logic [1:0] {
		MS_ENV,
		MS_GAIN,
		MS_LEFT,
		MS_RIGHT
	} msel_t;

	typedef enum logic [1:0] {
		JC_NEVER,
		JC_NO_INPUT,
		JC_OUT_BUSY
	} jcond_t;

	localparam int STEP_BITS = 4;
	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t ST_WAIT = 4'd0;
	localparam step_t ST_EMUL = 4'd1;
	localparam step_t ST_ENV  = 4'd2;
	localparam step_t ST_GATE = 4'd3;
	localparam step_t ST_GMUL = 4'd4;
	localparam step_t ST_GAIN = 4'd5;
	localparam step_t ST_LMUL = 4'd6;
	localparam step_t ST_RMUL = 4'd7;
	localparam step_t ST_ROUT = 4'd8;

	typedef struct packed {
		op_t    op;
		msel_t  msel;
		jcond_t jcond;
		step_t  jump_to;
		step_t  next;
	} uword_t;

	typedef struct packed {
		op_t   op;
		msel_t msel;
		logic  exec;
	} dp_ctrl_t;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		w = '{op: OP_NONE, msel: MS_ENV, jcond: JC_NEVER, jump_to: ST_WAIT, next: ST_WAIT};
		case (s)
			ST_WAIT: w = '{op: OP_LOAD, msel: MS_ENV,   jcond: JC_NO_INPUT,
				jump_to: ST_WAIT, next: ST_EMUL};
			ST_EMUL: w = '{op: OP_NONE, msel: MS_ENV,   jcond: JC_NEVER,
				jump_to: ST_WAIT, next: ST_ENV};
			ST_ENV:  w = '{op: OP_ENV,  msel: MS_ENV,   jcond: JC_NEVER,
				jump_to: ST_WAIT, next: ST_GATE};
			ST_GATE: w = '{op: OP_GATE, msel: MS_GAIN,  jcond: JC_NEVER,
				jump_to: ST_WAIT, next: ST_GMUL};
			ST_GMUL: w = '{op: OP_NONE, msel: MS_GAIN,  jcond: JC_NEVER,
				jump_to: ST_WAIT, next: ST_GAIN};
			ST_GAIN: w = '{op: OP_GAIN, msel: MS_LEFT,  jcond: JC_NEVER,
				jump_to: ST_WAIT, next: ST_LMUL};
			ST_LMUL: w = '{op: OP_NONE, msel: MS_LEFT,  jcond: JC_NEVER,
				jump_to: ST_WAIT, next: ST_RMUL};
			ST_RMUL: w = '{op: OP_LOUT, msel: MS_RIGHT, jcond: JC_NEVER,
				jump_to: ST_WAIT, next: ST_ROUT};
			ST_ROUT: w = '{op: OP_ROUT, msel: MS_RIGHT, jcond: JC_OUT_BUSY,
				jump_to: ST_ROUT, next: ST_WAIT};
			default: w = '{op: OP_NONE, msel: MS_ENV, jcond: JC_NEVER,
				jump_to: ST_WAIT, next: ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ----- rtl/noise_gate_attack_hold_release_core.sv -----
// Stereo noise gate with envelope follower, hold counter and gain ramp.
// Input stream: one beat per stereo frame, left and right signed samples.
// Output stream: one beat per input beat, gated samples plus the gain and
// the gate state after that frame (open flag in tuser).
// Configuration: APB-style register port; the user writes it only while idle,
// which the block does not enforce. pready is tied high; a read returns the register value.
// Each accepted frame steps through WAIT, EMUL, ENV, GATE, GMUL, GAIN, LMUL,
// RMUL and ROUT before its output beat is presented; the microcode program
// steps through a single shared multiplier four times per frame.
// s_axis_tready is high only while the sequencer waits for a frame.
// The output beat sits in a register; the next frame is taken and worked
// on while it waits. If the receiver still stalls when the next result is
// ready, the sequencer holds on its last step until the beat is taken.
// Reset clears envelope, hold counter, gain and gate state (closed) and
// loads the register defaults; no output beat is pending after reset.
module noise_gate_attack_hold_release_core
	import ngahr_pkg::*;
#(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
	parameter int HOLD_BITS       = HOLD_BITS_DEF,
	parameter int IN_TW  = ((2 * SAMPLE_BITS + 7) / 8) * 8,
	parameter int OUT_TW = ((2 * SAMPLE_BITS + COEFF_FRAC_BITS + 1 + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [IN_TW-1:0]         s_axis_tdata,  // left_in, right_in
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [OUT_TW-1:0]        m_axis_tdata,  // left_out, right_out, gain_now
	output logic                     m_axis_tuser,  // open_flag
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_BITS-1:0] paddr,
	input  logic [CFG_DATA_BITS-1:0] pwdata,
	output logic [CFG_DATA_BITS-1:0] prdata,
	output logic                     pready
);

	localparam int SW = SAMPLE_BITS;
	localparam int CF = COEFF_FRAC_BITS;

	dp_ctrl_t             ctrl;
	logic                 out_busy;
	logic [SW-2:0]        threshold_level;
	logic [CF:0]          gate_attack_coeff, gate_release_coeff;
	logic [CF:0]          env_attack_coeff, env_release_coeff;
	logic [HOLD_BITS-1:0] hold_length;
	logic                 stereo_mode;
	logic signed [SW-1:0] left_out, right_out;
	logic [CF:0]          gain_now;

	ngahr_regs #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS),
		.HOLD_BITS      (HOLD_BITS)
	) u_regs (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.threshold_level   (threshold_level),
		.gate_attack_coeff (gate_attack_coeff),
		.gate_release_coeff(gate_release_coeff),
		.hold_length       (hold_length),
		.env_attack_coeff  (env_attack_coeff),
		.env_release_coeff (env_release_coeff),
		.stereo_mode       (stereo_mode)
	);

	ngahr_useq u_useq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.out_busy(out_busy),
		.in_ready(s_axis_tready),
		.ctrl    (ctrl)
	);

	ngahr_dp #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEFF_FRAC_BITS(COEFF_FRAC_BITS),
		.HOLD_BITS      (HOLD_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctrl              (ctrl),
		.left_in           ($signed(s_axis_tdata[SW-1:0])),
		.right_in          ($signed(s_axis_tdata[2*SW-1:SW])),
		.threshold_level   (threshold_level),
		.gate_attack_coeff (gate_attack_coeff),
		.gate_release_coeff(gate_release_coeff),
		.hold_length       (hold_length),
		.env_attack_coeff  (env_attack_coeff),
		.env_release_coeff (env_release_coeff),
		.stereo_mode       (stereo_mode),
		.out_ready         (m_axis_tready),
		.out_valid         (m_axis_tvalid),
		.out_busy          (out_busy),
		.left_out          (left_out),
		.right_out         (right_out),
		.open_flag         (m_axis_tuser),
		.gain_now          (gain_now)
	);

	assign m_axis_tdata = OUT_TW'({gain_now, $unsigned(right_out), $unsigned(left_out)});

endmodule

// ----- rtl/ngahr_useq.sv -----
module ngahr_useq
	import ngahr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     out_busy,
	output logic     in_ready,
	output dp_ctrl_t ctrl
);

	step_t  step_q;
	uword_t uw;
	logic   jump;

	assign uw = ucode(step_q);

	always_comb begin
		unique case (uw.jcond)
			JC_NO_INPUT: jump = !in_valid;
			JC_OUT_BUSY: jump = out_busy;
			default:     jump = 1'b0;
		endcase
	end

	assign ctrl.op   = uw.op;
	assign ctrl.msel = uw.msel;
	assign ctrl.exec = !jump;
	assign in_ready  = (step_q == ST_WAIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_WAIT;
		end else begin
			step_q <= jump ? uw.jump_to : uw.next;
		end
	end

endmodule

// ----- rtl/ngahr_regs.sv -----
module ngahr_regs
	import ngahr_pkg::*;
#(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
	parameter int HOLD_BITS       = HOLD_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [CFG_ADDR_BITS-1:0]   paddr,
	input  logic [CFG_DATA_BITS-1:0]   pwdata,
	output logic [CFG_DATA_BITS-1:0]   prdata,
	output logic                       pready,
	output logic [SAMPLE_BITS-2:0]     threshold_level,
	output logic [COEFF_FRAC_BITS:0]   gate_attack_coeff,
	output logic [COEFF_FRAC_BITS:0]   gate_release_coeff,
	output logic [HOLD_BITS-1:0]       hold_length,
	output logic [COEFF_FRAC_BITS:0]   env_attack_coeff,
	output logic [COEFF_FRAC_BITS:0]   env_release_coeff,
	output logic                       stereo_mode
);

	localparam int CW = COEFF_FRAC_BITS + 1;

	logic     wr;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_level    <= (SAMPLE_BITS-1)'(THRESHOLD_RST);
			gate_attack_coeff  <= CW'(GATE_ATTACK_RST);
			gate_release_coeff <= CW'(GATE_RELEASE_RST);
			hold_length        <= HOLD_BITS'(HOLD_RST);
			env_attack_coeff   <= CW'(ENV_ATTACK_RST);
			env_release_coeff  <= CW'(ENV_RELEASE_RST);
			stereo_mode        <= 1'(STEREO_RST);
		end else if (wr) begin
			case (idx)
				REG_THRESHOLD:    threshold_level    <= pwdata[SAMPLE_BITS-2:0];
				REG_GATE_ATTACK:  gate_attack_coeff  <= pwdata[CW-1:0];
				REG_GATE_RELEASE: gate_release_coeff <= pwdata[CW-1:0];
				REG_HOLD:         hold_length        <= pwdata[HOLD_BITS-1:0];
				REG_ENV_ATTACK:   env_attack_coeff   <= pwdata[CW-1:0];
				REG_ENV_RELEASE:  env_release_coeff  <= pwdata[CW-1:0];
				REG_STEREO:       stereo_mode        <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_THRESHOLD:    prdata = CFG_DATA_BITS'(threshold_level);
			REG_GATE_ATTACK:  prdata = CFG_DATA_BITS'(gate_attack_coeff);
			REG_GATE_RELEASE: prdata = CFG_DATA_BITS'(gate_release_coeff);
			REG_HOLD:         prdata = CFG_DATA_BITS'(hold_length);
			REG_ENV_ATTACK:   prdata = CFG_DATA_BITS'(env_attack_coeff);
			REG_ENV_RELEASE:  prdata = CFG_DATA_BITS'(env_release_coeff);
			REG_STEREO:       prdata = CFG_DATA_BITS'(stereo_mode);
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- rtl/ngahr_dp.sv -----
module ngahr_dp
	import ngahr_pkg::*;
#(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
	parameter int HOLD_BITS       = HOLD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_ctrl_t                      ctrl,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	input  logic [SAMPLE_BITS-2:0]        threshold_level,
	input  logic [COEFF_FRAC_BITS:0]      gate_attack_coeff,
	input  logic [COEFF_FRAC_BITS:0]      gate_release_coeff,
	input  logic [HOLD_BITS-1:0]          hold_length,
	input  logic [COEFF_FRAC_BITS:0]      env_attack_coeff,
	input  logic [COEFF_FRAC_BITS:0]      env_release_coeff,
	input  logic                          stereo_mode,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic                          out_busy,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          open_flag,
	output logic [COEFF_FRAC_BITS:0]      gain_now
);

	localparam int SW = SAMPLE_BITS;
	localparam int CF = COEFF_FRAC_BITS;
	localparam int AW = ((SW > CF + 1) ? SW : CF + 1) + 1;
	localparam int BW = CF + 2;
	localparam int PW = AW + BW;
	localparam logic [CF:0] ONE_Q = {1'b1, {CF{1'b0}}};
	localparam logic [PW-1:0] RND_UP = (PW'(1) << CF) - PW'(1);
	localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (CF - 1);
	localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [PW-1:0] SMIN = PW'(-(64'sd1 <<< (SW - 1)));

	logic signed [SW-1:0] left_q, right_q, lres_q;
	logic [SW-1:0]        level_q, env_q;
	logic                 open_q;
	logic [HOLD_BITS-1:0] hold_q;
	logic [CF:0]          gain_q;
	logic signed [PW-1:0] prod_q;

	logic [SW-1:0]        mag_l, mag_r, level_in, ediff, estep;
	logic                 lvl_gt;
	logic [CF:0]          ecoef_raw, ecoef, gcoef_raw, gcoef, gdiff, gstep, gain_new;
	logic [CF+1:0]        gsum;
	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] mul_p, rnd, shr;
	logic [PW-1:0]        up_sum;
	logic signed [SW-1:0] sat_res;

	assign mag_l    = left_in[SW-1] ? (~$unsigned(left_in) + 1'b1) : $unsigned(left_in);
	assign mag_r    = right_in[SW-1] ? (~$unsigned(right_in) + 1'b1) : $unsigned(right_in);
	assign level_in = (stereo_mode && (mag_r > mag_l)) ? mag_r : mag_l;

	assign lvl_gt    = level_q > env_q;
	assign ediff     = lvl_gt ? (level_q - env_q) : (env_q - level_q);
	assign ecoef_raw = lvl_gt ? env_attack_coeff : env_release_coeff;
	assign ecoef     = (ecoef_raw > ONE_Q) ? ONE_Q : ecoef_raw;

	assign gdiff     = open_q ? (ONE_Q - gain_q) : gain_q;
	assign gcoef_raw = open_q ? gate_attack_coeff : gate_release_coeff;
	assign gcoef     = (gcoef_raw > ONE_Q) ? ONE_Q : gcoef_raw;

	always_comb begin
		unique case (ctrl.msel)
			MS_ENV: begin
				mul_a = AW'({1'b0, ediff});
				mul_b = {1'b0, ecoef};
			end
			MS_GAIN: begin
				mul_a = AW'({1'b0, gcoef});
				mul_b = {1'b0, gdiff};
			end
			MS_LEFT: begin
				mul_a = AW'(left_q);
				mul_b = {1'b0, gain_q};
			end
			MS_RIGHT: begin
				mul_a = AW'(right_q);
				mul_b = {1'b0, gain_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign up_sum = $unsigned(prod_q) + RND_UP;
	assign estep  = up_sum[CF+SW-1:CF];
	assign gstep  = up_sum[2*CF:CF];
	assign gsum   = open_q ? ({1'b0, gain_q} + {1'b0, gstep}) : ({1'b0, gain_q} - {1'b0, gstep});
	assign gain_new = (gsum > {1'b0, ONE_Q}) ? ONE_Q : gsum[CF:0];

	assign rnd = prod_q + RND_HALF;
	assign shr = rnd >>> CF;

	always_comb begin
		priority if (shr > SMAX) begin
			sat_res = SMAX[SW-1:0];
		end else if (shr < SMIN) begin
			sat_res = SMIN[SW-1:0];
		end else begin
			sat_res = shr[SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (ctrl.exec && ctrl.op == OP_LOAD) begin
			left_q  <= left_in;
			right_q <= right_in;
			level_q <= level_in;
		end
		if (ctrl.exec && ctrl.op == OP_LOUT) begin
			lres_q <= sat_res;
		end
		if (ctrl.exec && ctrl.op == OP_ROUT) begin
			left_out  <= lres_q;
			right_out <= sat_res;
			open_flag <= open_q;
			gain_now  <= gain_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q  <= '0;
			open_q <= 1'b0;
			hold_q <= '0;
			gain_q <= '0;
		end else if (ctrl.exec) begin
			unique case (ctrl.op)
				OP_ENV: begin
					env_q <= lvl_gt ? (env_q + estep) : (env_q - estep);
				end
				OP_GATE: begin
					priority if (env_q >= {1'b0, threshold_level}) begin
						open_q <= 1'b1;
						hold_q <= hold_length;
					end else if (hold_q != '0) begin
						hold_q <= hold_q - 1'b1;
					end else begin
						open_q <= 1'b0;
					end
				end
				OP_GAIN: begin
					gain_q <= gain_new;
				end
				default: ;
			endcase
		end
	end

	assign out_busy = out_valid && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctrl.exec && ctrl.op == OP_ROUT) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

// ----- rtl/ngahr_chk.sv -----
`include "assert_macros.svh"

module ngahr_chk
	import ngahr_pkg::*;
#(
	parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
	parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF,
	parameter int OUT_TW = ((2 * SAMPLE_BITS + COEFF_FRAC_BITS + 1 + 7) / 8) * 8
) (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [OUT_TW-1:0] m_axis_tdata,
	input logic              m_axis_tuser
);

	localparam int SW = SAMPLE_BITS;
	localparam int CF = COEFF_FRAC_BITS;
	localparam logic [CF:0] ONE_Q = {1'b1, {CF{1'b0}}};

	logic [CF:0]     gain_obs;
	logic [2*SW-1:0] samples_obs;
	logic [OUT_TW:0] out_word;
	logic            in_beat;
	logic            in_idle;
	logic            out_stall;
	logic            out_mute;

	assign gain_obs    = m_axis_tdata[2*SW+CF:2*SW];
	assign samples_obs = m_axis_tdata[2*SW-1:0];
	assign out_word    = {m_axis_tuser, m_axis_tdata};
	assign in_beat     = s_axis_tvalid && s_axis_tready;
	assign in_idle     = s_axis_tready && !s_axis_tvalid;
	assign out_stall   = m_axis_tvalid && !m_axis_tready;
	assign out_mute    = m_axis_tvalid && (gain_obs == '0);

	`NG_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(out_word), "stalled beat changed")
	`NG_ASSERT_SAME(a_gain_range, m_axis_tvalid, gain_obs <= ONE_Q, "gain above unity")
	`NG_ASSERT_SAME(a_zero_gain, out_mute, samples_obs == '0, "closed gain passed signal")
	`NG_ASSERT_NEXT(a_one_at_time, in_beat, !s_axis_tready, "second frame taken while busy")
	`NG_ASSERT_NEXT(a_wait_ready, in_idle, s_axis_tready, "ready dropped while waiting")

endmodule

bind noise_gate_attack_hold_release_core ngahr_chk #(
	.SAMPLE_BITS    (SAMPLE_BITS),
	.COEFF_FRAC_BITS(COEFF_FRAC_BITS),
	.OUT_TW         (OUT_TW)
) u_ngahr_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

// ----- tb/sv/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ngahr_pkg::*;

	localparam longint UNITY      = 65536;
	localparam int     FRAC       = 16;
	localparam int     REG_SPARE  = 7;
	localparam int     SETTLE_CYC = 12;
	localparam longint CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic signed [23:0] left;
		logic signed [23:0] right;
		logic               open;
		logic [16:0]        gain;
	} gate_beat_t;

	typedef enum logic [1:0] {ROW_REG, ROW_FRAME, ROW_KNOWN} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		int                 idx;
		logic [31:0]        value;
		logic signed [23:0] l;
		logic signed [23:0] r;
		gate_beat_t         known;
	} stim_row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [47:0]              s_axis_tdata;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	logic [71:0]              m_axis_tdata;
	logic                     m_axis_tuser;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [CFG_ADDR_BITS-1:0] paddr;
	logic [CFG_DATA_BITS-1:0] pwdata;
	logic [CFG_DATA_BITS-1:0] prdata;
	logic                     pready;

	noise_gate_attack_hold_release_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// gate model registers and state
	logic [22:0] thr_q;
	logic [16:0] gate_att_q;
	logic [16:0] gate_rel_q;
	logic [16:0] hold_len_q;
	logic [16:0] env_att_q;
	logic [16:0] env_rel_q;
	logic        stereo_q;
	logic [23:0] env_q;
	logic        open_q;
	logic [16:0] hold_q;
	logic [16:0] gain_q;

	gate_beat_t pending_beats[$];
	gate_beat_t expected_beat;
	stim_row_t  directed_rows[$];
	int         mismatches;
	int         beats_seen;
	longint     cycles;
	int         calm_left;
	int         stall_left;
	bit         long_hold_done;

	initial begin
		clk = 1'b0;
	end

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint unity_clamp(logic [16:0] c);
		return (longint'(c) > UNITY) ? UNITY : longint'(c);
	endfunction

	function automatic longint ceil_step(longint c, longint d);
		return (c * d + UNITY - 1) >> FRAC;
	endfunction

	function automatic logic signed [23:0] scale_sample(logic signed [23:0] s, logic [16:0] g);
		longint p;
		p = longint'(s) * longint'(g);
		p = (p + (UNITY >> 1)) >>> FRAC;
		if (p > 8388607) p = 8388607;
		if (p < -8388608) p = -8388608;
		return p[23:0];
	endfunction

	function automatic void gate_reset();
		thr_q      = THRESHOLD_RST;
		gate_att_q = GATE_ATTACK_RST;
		gate_rel_q = GATE_RELEASE_RST;
		hold_len_q = HOLD_RST;
		env_att_q  = ENV_ATTACK_RST;
		env_rel_q  = ENV_RELEASE_RST;
		stereo_q   = STEREO_RST;
		env_q      = '0;
		open_q     = 1'b0;
		hold_q     = '0;
		gain_q     = '0;
	endfunction

	function automatic void gate_cfg_apply(int idx, logic [31:0] v);
		case (idx)
			REG_THRESHOLD:    thr_q      = v[22:0];
			REG_GATE_ATTACK:  gate_att_q = v[16:0];
			REG_GATE_RELEASE: gate_rel_q = v[16:0];
			REG_HOLD:         hold_len_q = v[16:0];
			REG_ENV_ATTACK:   env_att_q  = v[16:0];
			REG_ENV_RELEASE:  env_rel_q  = v[16:0];
			REG_STEREO:       stereo_q   = v[0];
			default: ;
		endcase
	endfunction

	function automatic gate_beat_t gate_predict(logic signed [23:0] l, logic signed [23:0] r);
		longint     lvl;
		longint     rmag;
		longint     e;
		longint     g;
		gate_beat_t b;
		lvl  = (l < 0) ? -longint'(l) : longint'(l);
		rmag = (r < 0) ? -longint'(r) : longint'(r);
		if (stereo_q && rmag > lvl) lvl = rmag;
		e = longint'(env_q);
		if (lvl > e) e = e + ceil_step(unity_clamp(env_att_q), lvl - e);
		else e = e - ceil_step(unity_clamp(env_rel_q), e - lvl);
		env_q = e[23:0];
		if (env_q >= {1'b0, thr_q}) begin
			open_q = 1'b1;
			hold_q = hold_len_q;
		end else if (hold_q > 0) begin
			hold_q = hold_q - 1'b1;
		end else begin
			open_q = 1'b0;
		end
		g = longint'(gain_q);
		if (open_q) g = g + ceil_step(unity_clamp(gate_att_q), UNITY - g);
		else g = g - ceil_step(unity_clamp(gate_rel_q), g);
		if (g > UNITY) g = UNITY;
		gain_q  = g[16:0];
		b.left  = scale_sample(l, gain_q);
		b.right = scale_sample(r, gain_q);
		b.open  = open_q;
		b.gain  = gain_q;
		return b;
	endfunction

	function automatic void add_reg(int idx, logic [31:0] v);
		stim_row_t row;
		row = '{kind: ROW_REG, idx: idx, value: v, l: '0, r: '0, known: '0};
		directed_rows = {directed_rows, row};
	endfunction

	function automatic void add_frame(logic signed [23:0] l, logic signed [23:0] r);
		stim_row_t row;
		row = '{kind: ROW_FRAME, idx: 0, value: '0, l: l, r: r, known: '0};
		directed_rows = {directed_rows, row};
	endfunction

	function automatic void add_known(logic signed [23:0] l, logic signed [23:0] r,
			logic signed [23:0] el, logic signed [23:0] er, logic eo, logic [16:0] eg);
		stim_row_t  row;
		gate_beat_t b;
		b.left  = el;
		b.right = er;
		b.open  = eo;
		b.gain  = eg;
		row = '{kind: ROW_KNOWN, idx: 0, value: '0, l: l, r: r, known: b};
		directed_rows = {directed_rows, row};
	endfunction

	function automatic logic signed [23:0] pick_sample(int unsigned amp);
		int unsigned r;
		logic [31:0] raw;
		logic [23:0] v;
		r   = $urandom_range(0, 99);
		raw = $urandom();
		if (amp >= 8388607) begin
			if (r < 3) return 24'h7FFFFF;
			if (r < 6) return 24'h800000;
			return raw[23:0];
		end
		raw = $urandom_range(0, amp);
		v   = raw[23:0];
		return ($urandom_range(0, 1) != 0) ? -v : v;
	endfunction

	function automatic int pick_gap();
		int unsigned r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm_left = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_coeff();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'd0;
		if (r == 1) return $urandom_range(65536, 131071);
		return $urandom_range(500, 65536);
	endfunction

	task automatic flag_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d, want %0d (beat %0d)", what, got, want, beats_seen);
		mismatches++;
	endtask

	task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r, bit known,
			gate_beat_t kb);
		gate_beat_t pb;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r, l};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pb = gate_predict(l, r);
		if (known) pb = kb;
		pending_beats = {pending_beats, pb};
		@(negedge clk);
	endtask

	task automatic idle_gap(int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic reg_write(int idx, logic [31:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CFG_ADDR_BITS'(idx * 4);
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		gate_cfg_apply(idx, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// receiver: random stalls plus one long hold-off
	always @(negedge clk) begin
		if (!long_hold_done && beats_seen >= 400) begin
			long_hold_done = 1'b1;
			stall_left = 300;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			case ($urandom_range(0, 99)) inside
				[0:7]:   stall_left = $urandom_range(1, 3);
				[8:9]:   stall_left = $urandom_range(10, 40);
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_beats.size() == 0) begin
				flag_mismatch("beat with nothing pending", 0, 0);
			end else begin
				expected_beat = pending_beats.pop_front();
				if ($signed(m_axis_tdata[23:0]) != expected_beat.left)
					flag_mismatch("left_out", longint'($signed(m_axis_tdata[23:0])),
						longint'(expected_beat.left));
				if ($signed(m_axis_tdata[47:24]) != expected_beat.right)
					flag_mismatch("right_out", longint'($signed(m_axis_tdata[47:24])),
						longint'(expected_beat.right));
				if (m_axis_tdata[64:48] != expected_beat.gain)
					flag_mismatch("gain_now", longint'(m_axis_tdata[64:48]),
						longint'(expected_beat.gain));
				if (m_axis_tuser != expected_beat.open)
					flag_mismatch("open_flag", longint'(m_axis_tuser),
						longint'(expected_beat.open));
			end
			beats_seen++;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int          ph;
		int          n;
		int          blen;
		int          per_phase;
		bit          loud;
		bit          paused;
		int unsigned amp;
		int unsigned quiet_amp;
		int unsigned loud_amp;
		logic signed [23:0] l;
		logic signed [23:0] r;
		logic [31:0] v_thr;
		logic [31:0] v_hold;

		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		mismatches     = 0;
		beats_seen     = 0;
		cycles         = 0;
		calm_left      = 0;
		stall_left     = 0;
		long_hold_done = 1'b0;
		paused         = 1'b0;
		gate_reset();

		// defaults after reset
		add_known(0, 0, 0, 0, 1'b0, 17'd0);
		add_frame(24'sh7FFFFF, -24'sh800000);
		add_frame(-24'sh800000, 24'sh7FFFFF);
		add_frame(1, -1);
		add_frame(0, 0);
		// full steps, attack above unity: samples pass unchanged
		add_reg(REG_THRESHOLD, 0);
		add_reg(REG_GATE_ATTACK, 131071);
		add_reg(REG_GATE_RELEASE, 0);
		add_reg(REG_HOLD, 0);
		add_reg(REG_ENV_ATTACK, 65536);
		add_reg(REG_ENV_RELEASE, 65536);
		add_reg(REG_STEREO, 1);
		add_known(24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, -24'sh800000, 1'b1, 17'd65536);
		add_known(-24'sh800000, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, 1'b1, 17'd65536);
		add_known(-1, 1, -1, 1, 1'b1, 17'd65536);
		add_known(0, 0, 0, 0, 1'b1, 17'd65536);
		// top threshold, mono, no hold
		add_reg(REG_THRESHOLD, 8388607);
		add_reg(REG_GATE_RELEASE, 65536);
		add_reg(REG_STEREO, 0);
		add_known(-24'sh800000, 0, -24'sh800000, 0, 1'b1, 17'd65536);
		add_known(0, -24'sh800000, 0, 0, 1'b0, 17'd0);
		add_known(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1, 17'd65536);
		add_known(24'sh7FFFFE, -24'sh800000, 0, 0, 1'b0, 17'd0);
		// write past the last register must not land
		add_reg(REG_SPARE, 0);
		add_frame(24'sh7FFFFF, 0);
		// hold countdown
		add_reg(REG_THRESHOLD, 40000);
		add_reg(REG_HOLD, 3);
		add_reg(REG_ENV_ATTACK, 20000);
		add_reg(REG_ENV_RELEASE, 30000);
		add_reg(REG_GATE_ATTACK, 30000);
		add_reg(REG_GATE_RELEASE, 20000);
		add_reg(REG_STEREO, 1);
		add_frame(300000, -5);
		add_frame(-2, 7);
		add_frame(3, -1);
		add_frame(0, 0);
		add_frame(1, 1);
		add_frame(0, 0);
		// zero coefficients freeze envelope and gain
		add_reg(REG_GATE_ATTACK, 0);
		add_reg(REG_GATE_RELEASE, 0);
		add_reg(REG_ENV_ATTACK, 0);
		add_reg(REG_ENV_RELEASE, 0);
		add_frame(24'sh7FFFFF, -24'sh800000);
		add_frame(12345, -12345);

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			case (directed_rows[i].kind)
				ROW_REG: begin
					settle();
					reg_write(directed_rows[i].idx, directed_rows[i].value);
				end
				ROW_FRAME: begin
					send_frame(directed_rows[i].l, directed_rows[i].r, 1'b0, '0);
					idle_gap(pick_gap());
				end
				default: begin
					send_frame(directed_rows[i].l, directed_rows[i].r, 1'b1,
						directed_rows[i].known);
					idle_gap(pick_gap());
				end
			endcase
		end

		per_phase = 105;
		for (ph = 0; ph < 8; ph++) begin
			settle();
			if (ph == 0) begin
				v_thr  = 0;
				v_hold = 0;
				reg_write(REG_THRESHOLD, v_thr);
				reg_write(REG_GATE_ATTACK, 0);
				reg_write(REG_GATE_RELEASE, 0);
				reg_write(REG_HOLD, v_hold);
				reg_write(REG_ENV_ATTACK, 0);
				reg_write(REG_ENV_RELEASE, 0);
				reg_write(REG_STEREO, 0);
			end else if (ph == 1) begin
				v_thr  = 8388607;
				v_hold = 131071;
				reg_write(REG_THRESHOLD, v_thr);
				reg_write(REG_GATE_ATTACK, 131071);
				reg_write(REG_GATE_RELEASE, 131071);
				reg_write(REG_HOLD, v_hold);
				reg_write(REG_ENV_ATTACK, 131071);
				reg_write(REG_ENV_RELEASE, 131071);
				reg_write(REG_STEREO, 1);
			end else begin
				v_thr  = ($urandom_range(0, 9) == 0) ? ($urandom() & 32'h7FFFFF)
					: $urandom_range(2000, 1000000);
				v_hold = ($urandom_range(0, 9) < 2) ? ($urandom() & 32'h1FFFF)
					: $urandom_range(0, 16);
				reg_write(REG_THRESHOLD, v_thr);
				reg_write(REG_GATE_ATTACK, pick_coeff());
				reg_write(REG_GATE_RELEASE, pick_coeff());
				reg_write(REG_HOLD, v_hold);
				reg_write(REG_ENV_ATTACK, pick_coeff());
				reg_write(REG_ENV_RELEASE, pick_coeff());
				reg_write(REG_STEREO, $urandom_range(0, 1));
			end
			quiet_amp = v_thr / 16;
			loud_amp  = (v_thr * 2 + 1000 > 8388607) ? 8388607 : v_thr * 2 + 1000;
			n = 0;
			while (n < per_phase) begin
				loud = $urandom_range(0, 1);
				blen = $urandom_range(1, 24);
				amp  = loud ? (($urandom_range(0, 1) != 0) ? 8388607 : loud_amp) : quiet_amp;
				repeat (blen) begin
					if (n < per_phase) begin
						l = pick_sample(amp);
						r = (!loud && !stereo_q) ? pick_sample(8388607) : pick_sample(amp);
						send_frame(l, r, 1'b0, '0);
						n++;
						if (ph == 3 && n == 50 && !paused) begin
							paused = 1'b1;
							settle();
						end else begin
							idle_gap(pick_gap());
						end
					end
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
